[design/mkes_pkg.sv]
// ----------------------------------------------------------------------------
// mkes_pkg
// Shared types and codes for the modifier-aware key event sequencer.
// ----------------------------------------------------------------------------
package mkes_pkg;

    localparam int unsigned MOD_BITS = 8;

    localparam logic [7:0] MOD_BASE_CODE = 8'hE0;

    // request kinds on the input tuser
    localparam logic [1:0] ACT_TAP         = 2'd0;
    localparam logic [1:0] ACT_RAW_PRESS   = 2'd1;
    localparam logic [1:0] ACT_RAW_RELEASE = 2'd2;
    localparam logic [1:0] ACT_FLUSH       = 2'd3;

    // what the back end does with the key once the modifiers are done
    localparam logic [1:0] KEY_NONE    = 2'd0;
    localparam logic [1:0] KEY_TAP     = 2'd1;
    localparam logic [1:0] KEY_PRESS   = 2'd2;
    localparam logic [1:0] KEY_RELEASE = 2'd3;

    typedef struct packed {
        logic [MOD_BITS-1:0] rel_mask;
        logic [MOD_BITS-1:0] prs_mask;
        logic [7:0]          key;
        logic [1:0]          key_mode;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

endpackage

[design/mkes_front.sv]
// ----------------------------------------------------------------------------
// mkes_front
// Accepts requests, tracks the held modifier set and turns each request into
// a release mask, a press mask and a key action for the back end.
// ----------------------------------------------------------------------------
module mkes_front #(
    parameter int MOD_COUNT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_action,
    input  logic [7:0]        i_key_code,
    input  logic [7:0]        i_modifier_set,
    output logic              o_push,
    output mkes_pkg::t_cmd    o_cmd,
    input  logic              i_q_full
);

    localparam logic [7:0] MOD_MASK =
        (MOD_COUNT >= 8) ? 8'hFF : 8'((1 << MOD_COUNT) - 1);

    logic [7:0]     r_held;
    logic [7:0]     n_held;
    logic [7:0]     want;
    logic           accept;
    mkes_pkg::t_cmd cmd;

    assign o_ready = !i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign want    = i_modifier_set & MOD_MASK;

    always_comb begin
        cmd.rel_mask = r_held;
        cmd.prs_mask = '0;
        cmd.key      = i_key_code;
        cmd.key_mode = mkes_pkg::KEY_NONE;
        n_held       = '0;
        case (i_action)
            mkes_pkg::ACT_TAP: begin
                cmd.rel_mask = r_held & ~want;
                cmd.prs_mask = want & ~r_held;
                cmd.key_mode = mkes_pkg::KEY_TAP;
                n_held       = want;
            end
            mkes_pkg::ACT_RAW_PRESS: begin
                cmd.key_mode = mkes_pkg::KEY_PRESS;
            end
            mkes_pkg::ACT_RAW_RELEASE: begin
                cmd.key_mode = mkes_pkg::KEY_RELEASE;
            end
            default: begin
                cmd.key_mode = mkes_pkg::KEY_NONE;
            end
        endcase
    end

    // drop a flush that has nothing to release
    assign o_push = accept && ((cmd.key_mode != mkes_pkg::KEY_NONE) || (r_held != '0));
    assign o_cmd  = cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= '0;
        end else if (accept) begin
            r_held <= n_held;
        end
    end

endmodule

[design/mkes_queue.sv]
// ----------------------------------------------------------------------------
// mkes_queue
// Two-entry command queue between the front and back ends.
// ----------------------------------------------------------------------------
module mkes_queue (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  mkes_pkg::t_cmd      i_cmd,
    input  logic                i_pop,
    output mkes_pkg::t_cmd      o_cmd,
    output mkes_pkg::t_q_status o_status
);

    localparam int DEPTH = 2;
    localparam int AW    = $clog2(DEPTH);

    mkes_pkg::t_cmd     r_mem [DEPTH];
    logic [AW-1:0]      r_wr_ptr;
    logic [AW-1:0]      r_rd_ptr;
    logic [AW:0]        r_count;
    logic               do_push;
    logic               do_pop;

    assign o_status.full  = (r_count == (AW+1)'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push = i_push && !o_status.full;
    assign do_pop  = i_pop && !o_status.empty;
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

[design/mkes_back.sv]
// ----------------------------------------------------------------------------
// mkes_back
// Walks one command at a time: release modifiers, press modifiers, then the
// key action, one event per cycle while the output is not stalled, into a registered output.
// ----------------------------------------------------------------------------
module mkes_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mkes_pkg::t_cmd      i_cmd,
    input  logic                i_q_empty,
    output logic                o_pop,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_is_press,
    output logic [7:0]          o_event_code,
    output logic                o_last
);

    function automatic logic [2:0] f_low_idx(input logic [7:0] v);
        logic [2:0] idx;
        idx = '0;
        for (int i = 7; i >= 0; i--) begin
            if (v[i]) begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    logic           r_busy;
    logic [7:0]     r_rel;
    logic [7:0]     r_prs;
    logic [7:0]     r_key;
    logic [1:0]     r_kmode;
    logic           r_tap_down;
    logic           r_out_valid;
    logic           r_out_press;
    logic [7:0]     r_out_code;
    logic           r_out_last;

    logic           emit;
    logic           sel_rel;
    logic           sel_prs;
    logic [7:0]     cur_mask;
    logic [7:0]     n_rel;
    logic [7:0]     n_prs;
    logic           n_tap_down;
    logic           ev_press;
    logic [7:0]     ev_code;
    logic           ev_last;

    assign o_pop = !r_busy && !i_q_empty;
    assign emit  = r_busy && (!r_out_valid || i_ready);

    assign sel_rel  = (r_rel != '0);
    assign sel_prs  = !sel_rel && (r_prs != '0);
    assign cur_mask = sel_rel ? r_rel : r_prs;

    always_comb begin
        n_rel      = r_rel;
        n_prs      = r_prs;
        n_tap_down = r_tap_down;
        ev_press   = 1'b0;
        ev_code    = r_key;
        ev_last    = 1'b1;
        if (sel_rel || sel_prs) begin
            ev_press = sel_prs;
            ev_code  = mkes_pkg::MOD_BASE_CODE + {5'd0, f_low_idx(cur_mask)};
            // clear the lowest set bit
            if (sel_rel) begin
                n_rel = r_rel & (r_rel - 8'd1);
            end else begin
                n_prs = r_prs & (r_prs - 8'd1);
            end
            ev_last = (n_rel == '0) && (n_prs == '0) && (r_kmode == mkes_pkg::KEY_NONE);
        end else begin
            case (r_kmode)
                mkes_pkg::KEY_TAP: begin
                    ev_press   = !r_tap_down;
                    ev_last    = r_tap_down;
                    n_tap_down = 1'b1;
                end
                mkes_pkg::KEY_PRESS: begin
                    ev_press = 1'b1;
                end
                mkes_pkg::KEY_RELEASE: begin
                    ev_press = 1'b0;
                end
                default: begin
                    ev_press = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rel      <= i_cmd.rel_mask;
            r_prs      <= i_cmd.prs_mask;
            r_key      <= i_cmd.key;
            r_kmode    <= i_cmd.key_mode;
            r_tap_down <= 1'b0;
        end else if (emit) begin
            r_rel      <= n_rel;
            r_prs      <= n_prs;
            r_tap_down <= n_tap_down;
        end
        if (emit) begin
            r_out_press <= ev_press;
            r_out_code  <= ev_code;
            r_out_last  <= ev_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (emit && ev_last) begin
                r_busy <= 1'b0;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_is_press   = r_out_press;
    assign o_event_code = r_out_code;
    assign o_last       = r_out_last;

endmodule

[design/modifier_aware_key_event_sequencer_unit.sv]
// ----------------------------------------------------------------------------
// modifier_aware_key_event_sequencer_unit
// Tracks held keyboard modifiers and expands requests into key events.
// ----------------------------------------------------------------------------
// First event: with the queue empty and the walker idle, an accepted request
// is queued, loaded into the walker and its first event then registered out.
// Throughput: a request giving N events (1 to 10) occupies the event walker
// for a load step, then one event per cycle while the output is not stalled;
// a flush with nothing held is dropped in the front end and gives no events.
// A two-entry command queue lets requests be taken while the walker is busy.
// Reset (synchronous, active low) clears the held set, the queue and the
// output valid.
module modifier_aware_key_event_sequencer_unit #(
    parameter int MOD_COUNT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] key_code, [15:8] modifier_set
    input  logic [1:0]  i_s_axis_tuser,   // [1:0] action
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] event_code
    output logic        o_m_axis_tuser,   // [0] is_press
    output logic        o_m_axis_tlast
);

    logic                push;
    logic                pop;
    mkes_pkg::t_cmd      front_cmd;
    mkes_pkg::t_cmd      queue_cmd;
    mkes_pkg::t_q_status q_stat;

    mkes_front #(
        .MOD_COUNT(MOD_COUNT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_s_axis_tvalid),
        .o_ready        (o_s_axis_tready),
        .i_action       (i_s_axis_tuser),
        .i_key_code     (i_s_axis_tdata[7:0]),
        .i_modifier_set (i_s_axis_tdata[15:8]),
        .o_push         (push),
        .o_cmd          (front_cmd),
        .i_q_full       (q_stat.full)
    );

    mkes_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_cmd    (front_cmd),
        .i_pop    (pop),
        .o_cmd    (queue_cmd),
        .o_status (q_stat)
    );

    mkes_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (queue_cmd),
        .i_q_empty    (q_stat.empty),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_is_press   (o_m_axis_tuser),
        .o_event_code (o_m_axis_tdata),
        .o_last       (o_m_axis_tlast)
    );

    a_queue_sane : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    a_no_push_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_stat.full |-> !(i_s_axis_tvalid && o_s_axis_tready))
        else $error("request taken while command queue full");

    a_pop_needs_entry : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> !q_stat.empty)
        else $error("walker loaded from an empty queue");

    a_reset_quiet : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Stream-level check of the modifier-aware key event sequencer. Requests go
// in through the slave stream, and a scoreboard keeps its own copy of the
// held modifier set, so it can work out the press and release events that
// each accepted request should give. Every event on the master stream is
// compared with the oldest outstanding one. The run has directed corner
// cases, then random traffic under several idle and stall mixes, and one
// long output hold-off that backs up the request queue.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MOD_COUNT = 8;

    typedef struct packed {
        logic       is_press;
        logic [7:0] code;
        logic       last;
    } t_key_event;

    class key_event_scoreboard;
        logic [7:0]  held_mods;
        t_key_event  pending_events[$];
        int unsigned error_count;

        function new();
            held_mods   = 8'h00;
            error_count = 0;
        endfunction

        function logic [7:0] keep_mask();
            if (MOD_COUNT >= 8) return 8'hFF;
            if (MOD_COUNT <= 0) return 8'h00;
            return 8'((1 << MOD_COUNT) - 1);
        endfunction

        // walk the set lowest bit first
        function void push_modifiers(logic press, logic [7:0] mod_bits);
            t_key_event ev;
            for (int i = 0; i < 8; i++) begin
                if (mod_bits[i]) begin
                    ev.is_press = press;
                    ev.code     = mkes_pkg::MOD_BASE_CODE + 8'(i);
                    ev.last     = 1'b0;
                    pending_events.push_back(ev);
                end
            end
        endfunction

        function void push_key(logic press, logic [7:0] key);
            t_key_event ev;
            ev.is_press = press;
            ev.code     = key;
            ev.last     = 1'b0;
            pending_events.push_back(ev);
        endfunction

        function void note_request(logic [1:0] action, logic [7:0] key,
                                   logic [7:0] mods);
            logic [7:0]  want;
            logic [7:0]  held;
            int unsigned start_n;
            want    = mods & keep_mask();
            held    = held_mods & keep_mask();
            start_n = pending_events.size();
            case (action)
                mkes_pkg::ACT_TAP: begin
                    push_modifiers(1'b0, held & ~want);
                    push_modifiers(1'b1, want & ~held);
                    held_mods = want;
                    push_key(1'b1, key);
                    push_key(1'b0, key);
                end
                mkes_pkg::ACT_RAW_PRESS, mkes_pkg::ACT_RAW_RELEASE: begin
                    push_modifiers(1'b0, held);
                    held_mods = 8'h00;
                    push_key(action == mkes_pkg::ACT_RAW_PRESS, key);
                end
                default: begin
                    push_modifiers(1'b0, held);
                    held_mods = 8'h00;
                end
            endcase
            if (pending_events.size() > start_n)
                pending_events[pending_events.size() - 1].last = 1'b1;
        endfunction

        function void check_event(logic press, logic [7:0] code, logic last);
            t_key_event want_ev;
            if (pending_events.size() == 0) begin
                $display("%0t: unexpected event press=%0b code=%02h last=%0b",
                         $time, press, code, last);
                error_count++;
                return;
            end
            want_ev = pending_events.pop_front();
            if (want_ev.is_press !== press || want_ev.code !== code ||
                want_ev.last !== last) begin
                $display("%0t: event mismatch: expected press=%0b code=%02h last=%0b,",
                         $time, want_ev.is_press, want_ev.code, want_ev.last,
                         " got press=%0b code=%02h last=%0b", press, code, last);
                error_count++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [15:0] i_s_axis_tdata = 16'h0000;            // [7:0] key_code, [15:8] modifier_set
    logic [1:0]  i_s_axis_tuser = mkes_pkg::ACT_TAP;   // [1:0] action
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [7:0]  o_m_axis_tdata;                       // [7:0] event_code
    logic        o_m_axis_tuser;                       // [0] is_press
    logic        o_m_axis_tlast;

    key_event_scoreboard sb = new();

    int idle_pct  = 0;
    int stall_pct = 0;
    int hold_left = 0;

    modifier_aware_key_event_sequencer_unit #(
        .MOD_COUNT(MOD_COUNT)
    ) DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    always #4 i_clk = ~i_clk;

    // receiver: random stalls, or a counted hold-off when one is asked for
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            i_m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // note the request before checking, in case both land on one edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_request(i_s_axis_tuser, i_s_axis_tdata[7:0], i_s_axis_tdata[15:8]);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_event(o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
        end
    end

    task automatic send_request(input logic [1:0] action, input logic [7:0] key,
                                input logic [7:0] mods);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {mods, key};
        i_s_axis_tuser  <= action;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // mostly taps with varied modifier sets; the rest raw events and flushes
    task automatic random_request();
        int         pick;
        logic [1:0] action;
        logic [7:0] key;
        logic [7:0] mods;
        pick = $urandom_range(99);
        if (pick < 55)      action = mkes_pkg::ACT_TAP;
        else if (pick < 70) action = mkes_pkg::ACT_RAW_PRESS;
        else if (pick < 85) action = mkes_pkg::ACT_RAW_RELEASE;
        else                action = mkes_pkg::ACT_FLUSH;
        pick = $urandom_range(9);
        if (pick == 0)      key = 8'h00;
        else if (pick == 1) key = 8'hFF;
        else                key = 8'($urandom_range(255));
        pick = $urandom_range(9);
        if (pick == 0)      mods = 8'h00;
        else if (pick == 1) mods = 8'hFF;
        else if (pick == 2) mods = sb.held_mods;
        else if (pick == 3) mods = sb.held_mods ^ (8'h01 << $urandom_range(7));
        else                mods = 8'($urandom_range(255));
        send_request(action, key, mods);
    endtask

    task automatic run_phase(input int idle, input int stall, input int count);
        idle_pct  = idle;
        stall_pct = stall;
        repeat (count) random_request();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corner cases
        send_request(mkes_pkg::ACT_FLUSH,       8'h00, 8'h00);  // flush with nothing held
        send_request(mkes_pkg::ACT_TAP,         8'h00, 8'h00);  // key code zero, no modifiers
        send_request(mkes_pkg::ACT_TAP,         8'hFF, 8'hFF);  // press every modifier
        send_request(mkes_pkg::ACT_TAP,         8'h04, 8'hFF);  // same set held: key only
        send_request(mkes_pkg::ACT_TAP,         8'h05, 8'h00);  // release every modifier
        send_request(mkes_pkg::ACT_TAP,         8'h06, 8'hAA);
        send_request(mkes_pkg::ACT_TAP,         8'h07, 8'h55);  // swap every bit
        send_request(mkes_pkg::ACT_RAW_PRESS,   8'h2C, 8'hFF);  // releases held, ignores field
        send_request(mkes_pkg::ACT_RAW_RELEASE, 8'h2C, 8'h0F);
        send_request(mkes_pkg::ACT_TAP,         8'h1E, 8'h0F);
        send_request(mkes_pkg::ACT_RAW_RELEASE, 8'hFF, 8'h00);
        send_request(mkes_pkg::ACT_TAP,         8'h1F, 8'hF0);
        send_request(mkes_pkg::ACT_FLUSH,       8'hFF, 8'hFF);  // flush, right-hand held
        send_request(mkes_pkg::ACT_FLUSH,       8'h12, 8'h34);
        send_request(mkes_pkg::ACT_RAW_PRESS,   8'h00, 8'h00);  // raw with nothing held
        send_request(mkes_pkg::ACT_TAP,         8'h80, 8'h01);
        send_request(mkes_pkg::ACT_TAP,         8'h80, 8'h80);
        send_request(mkes_pkg::ACT_TAP,         8'h3A, 8'hFF);
        send_request(mkes_pkg::ACT_RAW_PRESS,   8'hE3, 8'h00);  // nine-event chain: release all held, then key
        send_request(mkes_pkg::ACT_TAP,         8'hFF, 8'hFF);
        send_request(mkes_pkg::ACT_FLUSH,       8'h00, 8'h00);

        run_phase(0,  0,  100);
        run_phase(47, 0,  100);
        run_phase(0,  47, 100);
        run_phase(30, 30, 100);

        // long output hold-off while requests keep coming: back up the queue
        @(posedge i_clk);
        hold_left = 300;
        run_phase(0, 0, 40);
        run_phase(0, 0, 60);

        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;

        while (sb.pending_events.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (sb.error_count == 0 && sb.pending_events.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("testbench: FAIL");
        $finish;
    end

endmodule
